// ----- hw/rtl/crossbridge_euler_step_defines.svh -----
// assertion macros shared by the block
`ifndef CROSSBRIDGE_EULER_STEP_DEFINES_SVH
`define CROSSBRIDGE_EULER_STEP_DEFINES_SVH

// a condition at one edge implies another at the same edge
`define CES_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("implication failed");

// a condition at one edge implies another at the next edge
`define CES_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/ces_pkg.sv -----
package ces_pkg;
   localparam int unsigned NumRegs = 8;
   localparam int unsigned RegIdxW = 3;

   localparam logic [RegIdxW-1:0] RegStepSize  = 3'd0;
   localparam logic [RegIdxW-1:0] RegRateTwo   = 3'd1;
   localparam logic [RegIdxW-1:0] RegRateThree = 3'd2;
   localparam logic [RegIdxW-1:0] RegRateFour  = 3'd3;
   localparam logic [RegIdxW-1:0] RegDetach    = 3'd4;
   localparam logic [RegIdxW-1:0] RegDetachFree= 3'd5;
   localparam logic [RegIdxW-1:0] RegK1Gain    = 3'd6;
   localparam logic [RegIdxW-1:0] RegKaGain    = 3'd7;

   localparam logic [30:0] StepSizeRst  = 31'd66;
   localparam logic [30:0] RateTwoRst   = 31'd8323072;
   localparam logic [30:0] RateThreeRst = 31'd1966080;
   localparam logic [30:0] RateFourRst  = 31'd196608;
   localparam logic [30:0] DetachRst    = 31'd4390912;
   localparam logic [30:0] DetachFreeRst= 31'd9109504;
   localparam logic [30:0] K1GainRst    = 31'd65536;
   localparam logic [30:0] KaGainRst    = 31'd65536;

   localparam logic signed [31:0] K1Offset   = 32'sd19661;
   localparam logic signed [31:0] KaOffset   = 32'sd196608;
   localparam logic signed [31:0] TncaInit   = 32'sd4587520;
   localparam logic signed [31:0] MyosinInit = 32'sd1310720;

   localparam logic signed [31:0] SatMax = 32'sh7fffffff;
   localparam logic signed [31:0] SatMin = 32'sh80000000;

   // multiplier command from sequencer
   typedef struct packed {
      logic               start;
      logic signed [32:0] op_a;
      logic signed [32:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] value;
      logic               sat;
   } mul_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return SatMax;
      end else if (v < -35'sd2147483648) begin
         return SatMin;
      end
      return v[31:0];
   endfunction

   function automatic logic sat32_hit(input logic signed [34:0] v);
      return (v > 35'sd2147483647) || (v < -35'sd2147483648);
   endfunction
endpackage

// ----- hw/rtl/ces_mul.sv -----
// 33x33 signed multiply: product built from the low 16 bits and the high 17 bits of b
module ces_mul
   import ces_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);
   typedef enum logic [1:0] {IDLE, LOW, HIGH, ROUND} mstate_type;

   mstate_type          state_ff;
   logic signed [32:0]  a_ff;
   logic signed [32:0]  b_ff;
   logic signed [66:0]  acc_ff;
   logic signed [31:0]  val_ff;
   logic                sat_ff;
   logic                done_ff;

   logic signed [50:0]  part_lo;
   logic signed [50:0]  part_hi;
   logic signed [66:0]  rounded;
   logic signed [50:0]  shifted;

   assign part_lo = a_ff * $signed({1'b0, b_ff[15:0]});
   assign part_hi = a_ff * $signed(b_ff[32:16]);
   assign rounded = acc_ff + 67'sd32768;
   // floor shift gives round half up
   assign shifted = rounded[66:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == ROUND);
         case (state_ff)
            IDLE: begin
               if (req.start) begin
                  a_ff     <= req.op_a;
                  b_ff     <= req.op_b;
                  state_ff <= LOW;
               end
            end
            LOW: begin
               acc_ff   <= 67'(part_lo);
               state_ff <= HIGH;
            end
            HIGH: begin
               acc_ff   <= acc_ff + (67'(part_hi) <<< 16);
               state_ff <= ROUND;
            end
            ROUND: begin
               if (shifted > 51'sd2147483647) begin
                  val_ff <= SatMax;
                  sat_ff <= 1'b1;
               end else if (shifted < -51'sd2147483648) begin
                  val_ff <= SatMin;
                  sat_ff <= 1'b1;
               end else begin
                  val_ff <= shifted[31:0];
                  sat_ff <= 1'b0;
               end
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = val_ff;
   assign rsp.sat   = sat_ff;
endmodule

// ----- hw/rtl/ces_sqrt.sv -----
// bit-pair integer square root of a 48-bit value, two result bits per cycle
module ces_sqrt
   import ces_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] radicand,
   output logic        done,
   output logic [23:0] root
);
   logic [47:0] rem_ff;
   logic [47:0] x_ff;
   logic [23:0] res_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [49:0] t1;
   logic [49:0] r1;
   logic [23:0] q1;
   logic [49:0] t2;
   logic [49:0] r2;
   logic [23:0] q2;
   logic [49:0] cand1;
   logic [49:0] cand2;

   always_comb begin
      t1    = {rem_ff, x_ff[47:46]};
      cand1 = {24'd0, res_ff, 2'b01};
      if (t1 >= cand1) begin
         r1 = t1 - cand1;
         q1 = {res_ff[22:0], 1'b1};
      end else begin
         r1 = t1;
         q1 = {res_ff[22:0], 1'b0};
      end
      t2    = {r1[47:0], x_ff[45:44]};
      cand2 = {24'd0, q1, 2'b01};
      if (t2 >= cand2) begin
         r2 = t2 - cand2;
         q2 = {q1[22:0], 1'b1};
      end else begin
         r2 = t2;
         q2 = {q1[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 5'd11);
         if (start) begin
            rem_ff  <= '0;
            x_ff    <= radicand;
            res_ff  <= '0;
            cnt_ff  <= 5'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= r2[47:0];
            res_ff <= q2;
            x_ff   <= {x_ff[43:0], 4'd0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd11) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff;
endmodule

// ----- hw/rtl/crossbridge_euler_step.sv -----
// Forward-Euler cross-bridge kinetics step in signed Q16.16 with saturation.
// func 1 restores the initial state and its result word is valid the cycle
// after the input word is taken. For func 0 nineteen multiplies run one
// after another through a single shared multiplier, one SUMS state goes to
// the rate sums and another to the bound sum, and the square root for K1
// runs beside the square and Ka multiplies, with SQRT_WAIT holding until it
// is done. The block takes no new word until the result word has been taken.
`include "crossbridge_euler_step_defines.svh"
module crossbridge_euler_step
   import ces_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [30:0]        req_calcium,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_activation,
   output logic signed [31:0] rsp_free_troponin,
   output logic signed [31:0] rsp_free_myosin,
   output logic signed [31:0] rsp_bound_calcium,
   output logic signed [31:0] rsp_bound_calcium_myosin,
   output logic signed [31:0] rsp_bound_myosin,
   output logic signed [31:0] rsp_coeff_k1,
   output logic signed [31:0] rsp_coeff_ka,
   output logic               rsp_saturated,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_data
);
   typedef enum logic [2:0] {IDLE, MUL_GO, MUL_WAIT, SUMS, SQRT_WAIT, RESP} state_type;

   // multiply steps in order
   localparam logic [4:0] MKct0 = 5'd0,  MKct1 = 5'd1,  MKat0 = 5'd2,  MKat1 = 5'd3,
                          MR3   = 5'd4,  MRdd  = 5'd5,  MRd   = 5'd6,  MR4   = 5'd7,
                          MR20  = 5'd8,  MR21  = 5'd9,  MU0   = 5'd10, MU1   = 5'd11,
                          MU2   = 5'd12, MU3   = 5'd13, MU4   = 5'd14, MU5   = 5'd15,
                          MSq   = 5'd16, MKa   = 5'd17, MK1   = 5'd18;

   state_type          state_ff;
   logic [4:0]         step_ff;
   logic [30:0]        regs_ff [NumRegs];
   logic [30:0]        ca_ff;
   logic signed [31:0] st_ff [8];
   logic signed [31:0] tmp_ff [8];
   logic signed [31:0] d_ff [6];
   logic               sat_ff;
   logic               rsp_valid_ff;
   logic               sq_start_ff;

   mul_req_type        mreq;
   mul_rsp_type        mrsp;
   logic               sq_done;
   logic [23:0]        sq_root;
   logic [47:0]        sq_radicand;
   logic signed [31:0] s_val;
   logic signed [34:0] s_sum;
   logic signed [32:0] op_a;
   logic signed [32:0] op_b;
   logic signed [34:0] acc_sum;
   logic signed [34:0] d_sum [6];
   logic [2:0]         u_idx;
   state_type          mul_next;

   ces_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   ces_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start_ff),
                    .radicand(sq_radicand), .done(sq_done), .root(sq_root));

   function automatic logic signed [32:0] u33(input logic [30:0] v);
      return $signed({2'b00, v});
   endfunction
   function automatic logic signed [32:0] s33(input logic signed [31:0] v);
      return 33'(v);
   endfunction

   assign u_idx = 3'(step_ff - MU0);

   // tmp: 0 kct,1 kat,2 r3,3 rdd,4 rd,5 r4,6 r2,7 scratch
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         MKct0: begin op_a = s33(st_ff[6]); op_b = u33(ca_ff); end
         MKct1: begin op_a = s33(tmp_ff[7]); op_b = s33(st_ff[1]); end
         MKat0: begin op_a = s33(st_ff[7]); op_b = s33(st_ff[3]); end
         MKat1: begin op_a = s33(tmp_ff[7]); op_b = s33(st_ff[2]); end
         MR3:   begin op_a = u33(regs_ff[RegRateThree]); op_b = s33(st_ff[3]); end
         MRdd:  begin op_a = u33(regs_ff[RegDetachFree]); op_b = s33(st_ff[5]); end
         MRd:   begin op_a = u33(regs_ff[RegDetach]); op_b = s33(st_ff[4]); end
         MR4:   begin op_a = u33(regs_ff[RegRateFour]); op_b = s33(st_ff[4]); end
         MR20:  begin op_a = u33(regs_ff[RegRateTwo]); op_b = u33(ca_ff); end
         MR21:  begin op_a = s33(tmp_ff[7]); op_b = s33(st_ff[5]); end
         MU0, MU1, MU2, MU3, MU4, MU5: begin
            op_a = u33(regs_ff[RegStepSize]);
            op_b = s33(d_ff[u_idx]);
         end
         MSq:   begin op_a = s33(s_val); op_b = s33(s_val); end
         MKa:   begin op_a = u33(regs_ff[RegKaGain]); op_b = s33(tmp_ff[7]); end
         MK1:   begin op_a = u33(regs_ff[RegK1Gain]); op_b = $signed({9'd0, sq_root}); end
         default: ;
      endcase
      mreq.start = (state_ff == MUL_GO);
      mreq.op_a  = op_a;
      mreq.op_b  = op_b;
   end

   always_comb begin
      case (step_ff)
         MR21, MU5: mul_next = SUMS;
         MKa:       mul_next = SQRT_WAIT;
         MK1:       mul_next = RESP;
         default:   mul_next = MUL_GO;
      endcase
   end

   assign s_sum = 35'(st_ff[4]) + 35'(st_ff[5]);
   assign s_val = sat32(s_sum);
   // a bound sum at or below zero takes a root of zero
   assign sq_radicand = s_val[31] ? 48'd0 : {s_val, 16'd0};

   always_comb begin
      d_sum[0] = 35'(st_ff[4]) + 35'(st_ff[5]);
      d_sum[1] = -35'(tmp_ff[0]) + 35'(tmp_ff[2]) + 35'(tmp_ff[3]);
      d_sum[2] = 35'(tmp_ff[3]) - 35'(tmp_ff[1]) + 35'(tmp_ff[4]);
      d_sum[3] = 35'(tmp_ff[0]) - 35'(tmp_ff[2]) - 35'(tmp_ff[1]) + 35'(tmp_ff[4]);
      d_sum[4] = 35'(tmp_ff[1]) + 35'(tmp_ff[6]) - 35'(tmp_ff[4]) - 35'(tmp_ff[5]);
      d_sum[5] = 35'(tmp_ff[5]) - 35'(tmp_ff[3]) - 35'(tmp_ff[6]);
      acc_sum  = '0;
      if (step_ff inside {[MU0:MU5]}) begin
         acc_sum = 35'(st_ff[u_idx]) + 35'(mrsp.value);
      end else if (step_ff == MKa) begin
         acc_sum = 35'(mrsp.value) + 35'(KaOffset);
      end else if (step_ff == MK1) begin
         acc_sum = 35'(mrsp.value) + 35'(K1Offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[RegStepSize]   <= StepSizeRst;
         regs_ff[RegRateTwo]    <= RateTwoRst;
         regs_ff[RegRateThree]  <= RateThreeRst;
         regs_ff[RegRateFour]   <= RateFourRst;
         regs_ff[RegDetach]     <= DetachRst;
         regs_ff[RegDetachFree] <= DetachFreeRst;
         regs_ff[RegK1Gain]     <= K1GainRst;
         regs_ff[RegKaGain]     <= KaGainRst;
      end else if (csr_write) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         step_ff      <= '0;
         st_ff[0] <= '0; st_ff[1] <= TncaInit; st_ff[2] <= MyosinInit; st_ff[3] <= '0;
         st_ff[4] <= '0; st_ff[5] <= '0; st_ff[6] <= K1Offset; st_ff[7] <= KaOffset;
         sat_ff   <= 1'b0;
      end else begin
         sq_start_ff <= (state_ff == SUMS) && (step_ff != MU0);
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  ca_ff   <= req_calcium;
                  sat_ff  <= 1'b0;
                  step_ff <= MKct0;
                  if (req_func) begin
                     st_ff[0] <= '0; st_ff[1] <= TncaInit; st_ff[2] <= MyosinInit;
                     st_ff[3] <= '0; st_ff[4] <= '0; st_ff[5] <= '0;
                     st_ff[6] <= K1Offset; st_ff[7] <= KaOffset;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= RESP;
                  end else begin
                     state_ff <= MUL_GO;
                  end
               end
            end
            MUL_GO: state_ff <= MUL_WAIT;
            MUL_WAIT: begin
               if (mrsp.done) begin
                  // acc_sum is zero on steps that add nothing
                  sat_ff   <= sat_ff | mrsp.sat | sat32_hit(acc_sum);
                  step_ff  <= step_ff + 5'd1;
                  state_ff <= mul_next;
                  case (step_ff)
                     MKct0, MKat0, MR20, MSq: tmp_ff[7] <= mrsp.value;
                     MKct1: tmp_ff[0] <= mrsp.value;
                     MKat1: tmp_ff[1] <= mrsp.value;
                     MR3:   tmp_ff[2] <= mrsp.value;
                     MRdd:  tmp_ff[3] <= mrsp.value;
                     MRd:   tmp_ff[4] <= mrsp.value;
                     MR4:   tmp_ff[5] <= mrsp.value;
                     MR21:  tmp_ff[6] <= mrsp.value;
                     MU0, MU1, MU2, MU3, MU4, MU5: st_ff[u_idx] <= sat32(acc_sum);
                     MKa:   st_ff[7] <= sat32(acc_sum);
                     MK1: begin
                        st_ff[6]     <= sat32(acc_sum);
                        rsp_valid_ff <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            SUMS: begin
               if (step_ff == MU0) begin
                  for (int i = 0; i < 6; i++) begin
                     d_ff[i] <= sat32(d_sum[i]);
                  end
                  sat_ff <= sat_ff | sat32_hit(d_sum[0]) | sat32_hit(d_sum[1]) |
                            sat32_hit(d_sum[2]) | sat32_hit(d_sum[3]) |
                            sat32_hit(d_sum[4]) | sat32_hit(d_sum[5]);
                  state_ff <= MUL_GO;
               end else begin
                  // clamped bound sum feeds the root and the square
                  sat_ff   <= sat_ff | sat32_hit(s_sum);
                  state_ff <= MUL_GO;
               end
            end
            SQRT_WAIT: begin
               if (sq_done) begin
                  state_ff <= MUL_GO;
               end
            end
            RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_activation           = st_ff[0];
   assign rsp_free_troponin        = st_ff[1];
   assign rsp_free_myosin          = st_ff[2];
   assign rsp_bound_calcium        = st_ff[3];
   assign rsp_bound_calcium_myosin = st_ff[4];
   assign rsp_bound_myosin         = st_ff[5];
   assign rsp_coeff_k1             = st_ff[6];
   assign rsp_coeff_ka             = st_ff[7];
   assign rsp_saturated            = sat_ff;

   `CES_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `CES_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `CES_ASSERT_IMP(a_mul_idle_start, clock, reset, mreq.start, state_ff == MUL_GO)
endmodule
